FILE: sv/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// shared constants and types of the digit-sum stable sorter
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int VAL_W     = 31;
	localparam int KEY_W     = 7;
	localparam int DIG_W     = 4;
	localparam int NUM_DIGITS = 10;

	localparam logic [DIG_W-1:0] DIGIT_BASE  = 4'd10;
	localparam logic [31:0]      RECIP_10    = 32'hCCCC_CCCD;
	localparam int               RECIP_SHIFT = 35;
	localparam logic [NUM_DIGITS-1:0] ALL_DIGITS = '1;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [NUM_DIGITS-1:0] digit_oh;
		logic [KEY_W-1:0]      key;
	} dss_digit_status_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [VAL_W-1:0] value;
		logic [KEY_W-1:0] key;
	} dss_wr_t;

endpackage

FILE: sv/digit_sum_stable_sorter.sv
// ----------------------------------------------------------------------------
// digit_sum_stable_sorter
// collects up to MAX_ITEMS numbers, keys them by decimal digit sum and emits
// them in stable key order once all ten digits have been seen
// requests: the shared digit unit sums the 1 to 10 decimal digits of each request;
//   once the store is full, further requests are dropped
// output: with n stored numbers each result needs a scan of the n entries over
//   the single read port of the store plus the output handshake; an incomplete
//   digit set gives one result once its last request is taken or dropped
// reset: asynchronous, clears control state and run counters, memories are not
//   cleared and entries are read only after being written
// ----------------------------------------------------------------------------
module digit_sum_stable_sorter
	import dss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] item_value
	input  logic        s_tlast,   // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [30:0] sorted_value
	output logic [1:0]  m_tuser,   // [0] all_digits, [1] overflow
	output logic        m_tlast    // last_result
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_FIND   = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	localparam int ORD_W = KEY_W + IDX_W;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [NUM_DIGITS-1:0] digits_q;
	logic                  ovf_q;
	logic                  last_q;
	logic [VAL_W-1:0]      value_q;

	logic [CNT_W-1:0]      scan_cnt_q;
	logic [CNT_W-1:0]      out_cnt_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  first_q;
	logic                  best_none_q;
	logic [ORD_W-1:0]      best_ord_q;
	logic [VAL_W-1:0]      best_val_q;
	logic [ORD_W-1:0]      last_ord_q;

	logic                  m_valid_q;
	logic [VAL_W-1:0]      m_value_q;
	logic                  m_all_q;
	logic                  m_ovf_q;
	logic                  m_last_q;

	logic                  in_req;
	logic                  out_req;
	logic                  has_room;
	logic                  dig_start;
	dss_digit_status_t     dig;
	dss_wr_t               wr;
	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic [VAL_W-1:0]      rd_value;
	logic [KEY_W-1:0]      rd_key;
	logic [ORD_W-1:0]      cand_ord;
	logic                  take;
	logic [ORD_W-1:0]      best_nxt_ord;
	logic [VAL_W-1:0]      best_nxt_val;
	logic [CNT_W-1:0]      count_m1;
	logic                  scan_end;

	assign s_tready = (state_q == ST_IDLE);
	assign in_req   = s_tvalid && s_tready;
	assign out_req  = m_valid_q && m_tready;
	assign has_room = (count_q < CNT_W'(MAX_ITEMS));
	assign dig_start = in_req && has_room;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_value_q};
	assign m_tuser  = {m_ovf_q, m_all_q};
	assign m_tlast  = m_last_q;

	dss_digit_unit u_digit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dig_start),
		.value  (s_tdata[VAL_W-1:0]),
		.status (dig)
	);

	always_comb begin
		wr       = '0;
		wr.en    = (state_q == ST_SCAN) && dig.done;
		wr.addr  = count_q[IDX_W-1:0];
		wr.value = value_q;
		wr.key   = dig.key;
	end

	assign rd_en   = (state_q == ST_FIND) && (scan_cnt_q < count_q);
	assign rd_addr = scan_cnt_q[IDX_W-1:0];

	dss_store u_store (
		.clk      (clk),
		.wr       (wr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_value (rd_value),
		.rd_key   (rd_key)
	);

	// next smallest (key, index) above the one sent last
	assign cand_ord     = {rd_key, rd_idx_s1};
	assign take         = rd_vld_s1 && (first_q || (cand_ord > last_ord_q))
	                      && (best_none_q || (cand_ord < best_ord_q));
	assign best_nxt_ord = take ? cand_ord : best_ord_q;
	assign best_nxt_val = take ? rd_value : best_val_q;
	assign count_m1     = count_q - CNT_W'(1);
	assign scan_end     = rd_vld_s1 && (CNT_W'(rd_idx_s1) == count_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			digits_q    <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			scan_cnt_q  <= '0;
			out_cnt_q   <= '0;
			rd_vld_s1   <= 1'b0;
			first_q     <= 1'b1;
			best_none_q <= 1'b1;
			m_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						last_q <= s_tlast;
						if (has_room) begin
							state_q <= ST_SCAN;
						end else begin
							ovf_q <= 1'b1;
							if (s_tlast) begin
								state_q <= ST_DECIDE;
							end
						end
					end
				end
				ST_SCAN: begin
					digits_q <= digits_q | dig.digit_oh;
					if (dig.done) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= last_q ? ST_DECIDE : ST_IDLE;
					end
				end
				ST_DECIDE: begin
					if (digits_q == ALL_DIGITS) begin
						state_q     <= ST_FIND;
						first_q     <= 1'b1;
						out_cnt_q   <= '0;
						scan_cnt_q  <= '0;
						rd_vld_s1   <= 1'b0;
						best_none_q <= 1'b1;
					end else begin
						state_q   <= ST_OUT;
						m_valid_q <= 1'b1;
					end
				end
				ST_FIND: begin
					rd_vld_s1 <= rd_en;
					if (rd_en) begin
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end
					if (take) begin
						best_none_q <= 1'b0;
					end
					if (scan_end) begin
						state_q   <= ST_OUT;
						m_valid_q <= 1'b1;
						first_q   <= 1'b0;
					end
				end
				ST_OUT: begin
					if (out_req) begin
						m_valid_q <= 1'b0;
						if (m_last_q) begin
							state_q  <= ST_IDLE;
							count_q  <= '0;
							digits_q <= '0;
							ovf_q    <= 1'b0;
						end else begin
							state_q     <= ST_FIND;
							out_cnt_q   <= out_cnt_q + CNT_W'(1);
							scan_cnt_q  <= '0;
							rd_vld_s1   <= 1'b0;
							best_none_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dig_start) begin
			value_q <= s_tdata[VAL_W-1:0];
		end
		if (rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
		if (state_q == ST_FIND) begin
			best_ord_q <= best_nxt_ord;
			best_val_q <= best_nxt_val;
		end
		if ((state_q == ST_FIND) && scan_end) begin
			last_ord_q <= best_nxt_ord;
			m_value_q  <= best_nxt_val;
			m_all_q    <= 1'b1;
			m_ovf_q    <= ovf_q;
			m_last_q   <= (out_cnt_q == count_m1);
		end else if ((state_q == ST_DECIDE) && (digits_q != ALL_DIGITS)) begin
			m_value_q <= '0;
			m_all_q   <= 1'b0;
			m_ovf_q   <= ovf_q;
			m_last_q  <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("item count beyond capacity");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && (count_q == '0)))
		else $error("run state not cleared after final result");

	a_unsorted_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
		else $error("unsorted result must be single and zero");
`endif

endmodule

FILE: sv/dss_digit_unit.sv
// ----------------------------------------------------------------------------
// dss_digit_unit
// iterative decimal digit extractor, one digit per cycle via reciprocal multiply
// ----------------------------------------------------------------------------
module dss_digit_unit
	import dss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [VAL_W-1:0]  value,
	output dss_digit_status_t status
);

	logic             busy_q;
	logic [VAL_W-1:0] v_q;
	logic [KEY_W-1:0] sum_q;
	logic [63:0]      prod;
	logic [VAL_W-1:0] quot;
	logic [DIG_W-1:0] q_times_ten;
	logic [DIG_W-1:0] digit;

	assign prod        = {33'd0, v_q} * {32'd0, RECIP_10};
	assign quot        = VAL_W'(prod >> RECIP_SHIFT);
	assign q_times_ten = DIG_W'(quot[DIG_W-1:0] * DIGIT_BASE);
	assign digit       = v_q[DIG_W-1:0] - q_times_ten;

	always_comb begin
		status          = '0;
		status.busy     = busy_q;
		status.done     = busy_q && (quot == '0);
		status.key      = sum_q + KEY_W'(digit);
		if (busy_q) begin
			status.digit_oh = NUM_DIGITS'(1) << digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (quot == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			sum_q <= '0;
		end else if (busy_q) begin
			v_q   <= quot;
			sum_q <= sum_q + KEY_W'(digit);
		end
	end

endmodule

FILE: sv/dss_store.sv
// ----------------------------------------------------------------------------
// dss_store
// value and key memories, one write port and one registered read port
// ----------------------------------------------------------------------------
module dss_store
	import dss_pkg::*;
(
	input  logic             clk,
	input  dss_wr_t          wr,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [VAL_W-1:0] rd_value,
	output logic [KEY_W-1:0] rd_key
);

	logic [VAL_W-1:0] value_mem [MAX_ITEMS];
	logic [KEY_W-1:0] key_mem   [MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			value_mem[wr.addr] <= wr.value;
			key_mem[wr.addr]   <= wr.key;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_value <= value_mem[rd_addr];
			rd_key   <= key_mem[rd_addr];
		end
	end

endmodule

FILE: bench/digit_sum_stable_sorter_tb.sv
// ----------------------------------------------------------------------------
// digit_sum_stable_sorter_tb
// self-checking bench: number sets go in on the slave stream and the sorted
// results are checked field by field against a digit-sum sort predictor
// ----------------------------------------------------------------------------
module digit_sum_stable_sorter_tb;
	import dss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES = 600;
	localparam int DIR_ROWS = 20;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             all_digits;
		logic             overflow;
		logic             last;
	} sorted_result_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             last;
		logic             typed;
		sorted_result_t   exp;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	sorted_result_t pending_results[$];
	logic [VAL_W-1:0] held_values[MAX_ITEMS];
	logic [KEY_W-1:0] held_keys[MAX_ITEMS];
	logic [NUM_DIGITS-1:0] digit_mask = '0;
	int  held_count = 0;
	logic dropped = 1'b0;

	int failures = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int items_sent = 0;

	// incomplete-digit rows, extremes and single pan-digit numbers are typed in
	stim_row_t directed_rows[DIR_ROWS] = '{
		'{31'd0,          1'b1, 1'b1, '{31'd0, 1'b0, 1'b0, 1'b1}},
		'{31'd2147483647, 1'b1, 1'b1, '{31'd0, 1'b0, 1'b0, 1'b1}},
		'{31'd1234567890, 1'b1, 1'b1, '{31'd1234567890, 1'b1, 1'b0, 1'b1}},
		'{31'd1987654320, 1'b1, 1'b1, '{31'd1987654320, 1'b1, 1'b0, 1'b1}},
		'{31'd9,          1'b0, 1'b0, '0},
		'{31'd18,         1'b0, 1'b0, '0},
		'{31'd0,          1'b0, 1'b0, '0},
		'{31'd1234567,    1'b0, 1'b0, '0},
		'{31'd81,         1'b0, 1'b0, '0},
		'{31'd27,         1'b0, 1'b0, '0},
		'{31'd345,        1'b0, 1'b0, '0},
		'{31'd6,          1'b1, 1'b0, '0},
		'{31'd5,          1'b0, 1'b0, '0},
		'{31'd55,         1'b0, 1'b0, '0},
		'{31'd1000000000, 1'b0, 1'b0, '0},
		'{31'd2147483647, 1'b1, 1'b1, '{31'd0, 1'b0, 1'b0, 1'b1}},
		'{31'd999999999,  1'b0, 1'b0, '0},
		'{31'd1999999999, 1'b0, 1'b0, '0},
		'{31'd0,          1'b0, 1'b0, '0},
		'{31'd2345678,    1'b1, 1'b0, '0}
	};

	digit_sum_stable_sorter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic void digit_scan(input logic [VAL_W-1:0] v, output logic [KEY_W-1:0] key,
			output logic [NUM_DIGITS-1:0] mask);
		int unsigned rest;
		int unsigned sum;
		int unsigned d;
		rest = v;
		sum = 0;
		mask = '0;
		if (rest == 0)
			mask[0] = 1'b1;
		while (rest != 0) begin
			d = rest % 10;
			mask[d] = 1'b1;
			sum += d;
			rest = rest / 10;
		end
		key = sum[KEY_W-1:0];
	endfunction

	// updates the run state and, on the last request, queues the sorted results or the single unsorted one
	function automatic void absorb_number(input logic [VAL_W-1:0] v, input logic last,
			input logic keep);
		logic [KEY_W-1:0] key;
		logic [NUM_DIGITS-1:0] mask;
		logic [VAL_W-1:0] vals[MAX_ITEMS];
		logic [KEY_W-1:0] keys[MAX_ITEMS];
		logic [VAL_W-1:0] mv;
		logic [KEY_W-1:0] mk;
		int i;
		int p;
		if (held_count < MAX_ITEMS) begin
			digit_scan(v, key, mask);
			held_values[held_count] = v;
			held_keys[held_count] = key;
			digit_mask |= mask;
			held_count++;
		end else begin
			dropped = 1'b1;
		end
		if (!last)
			return;
		if (digit_mask == ALL_DIGITS) begin
			for (i = 0; i < held_count; i++) begin
				vals[i] = held_values[i];
				keys[i] = held_keys[i];
			end
			for (i = 1; i < held_count; i++) begin
				mk = keys[i];
				mv = vals[i];
				p = i;
				while (p > 0 && keys[p-1] > mk) begin
					keys[p] = keys[p-1];
					vals[p] = vals[p-1];
					p--;
				end
				keys[p] = mk;
				vals[p] = mv;
			end
			if (keep)
				for (i = 0; i < held_count; i++)
					pending_results.push_back('{vals[i], 1'b1, dropped, i == held_count - 1});
		end else if (keep) begin
			pending_results.push_back('{'0, 1'b0, dropped, 1'b1});
		end
		digit_mask = '0;
		held_count = 0;
		dropped = 1'b0;
	endfunction

	function automatic logic [VAL_W-1:0] pan_digit_value();
		int unsigned d[9];
		int unsigned v;
		int unsigned t;
		int j;
		int k;
		d = '{0, 2, 3, 4, 5, 6, 7, 8, 9};
		for (j = 8; j > 0; j--) begin
			k = $urandom_range(0, j);
			t = d[j];
			d[j] = d[k];
			d[k] = t;
		end
		v = 1;
		for (j = 0; j < 9; j++)
			v = v * 10 + d[j];
		return v[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] random_value();
		int unsigned p;
		int unsigned r;
		int n;
		case ($urandom_range(0, 3))
			0: r = $urandom_range(0, 9);
			1: r = $urandom_range(0, 999);
			2: r = $urandom;
			default: begin
				n = $urandom_range(1, 9);
				p = 1;
				repeat (n) p = p * 10;
				r = $urandom % p;
			end
		endcase
		return r[VAL_W-1:0];
	endfunction

	task automatic send_number(input logic [VAL_W-1:0] v, input logic last, input logic keep);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata = {1'b0, v};
		s_tlast = last;
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		absorb_number(v, last, keep);
		items_sent++;
	endtask

	// pan_pos < 0 leaves the digit coverage to chance
	task automatic send_set(input int n, input int pan_pos);
		int i;
		for (i = 0; i < n; i++)
			send_number(i == pan_pos ? pan_digit_value() : random_value(), i == n - 1, 1'b1);
	endtask

	task automatic send_random_sets(input int budget);
		int n;
		int stop_at;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			n = $urandom_range(1, 8);
			if ($urandom_range(0, 99) < 70)
				send_set(n, $urandom_range(0, n - 1));
			else
				send_set(n, -1);
		end
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else begin
			m_tready = $urandom_range(0, 99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		sorted_result_t got;
		sorted_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[VAL_W-1:0], m_tuser[0], m_tuser[1], m_tlast};
			if (pending_results.size() == 0) begin
				$error("unexpected result: sorted_value %0d", got.value);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value) begin
					$error("sorted_value: expected %0d, actual %0d", want.value, got.value);
					failures++;
				end
				if (got.all_digits !== want.all_digits) begin
					$error("all_digits: expected %0b, actual %0b", want.all_digits,
						got.all_digits);
					failures++;
				end
				if (got.overflow !== want.overflow) begin
					$error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
					failures++;
				end
				if (got.last !== want.last) begin
					$error("last_result: expected %0b, actual %0b", want.last, got.last);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int r;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 12;
		recv_idle_pct = 78;
		for (r = 0; r < DIR_ROWS; r++) begin
			send_number(directed_rows[r].value, directed_rows[r].last, !directed_rows[r].typed);
			if (directed_rows[r].typed)
				pending_results.push_back(directed_rows[r].exp);
		end
		// over capacity: the dropped tail still closes the set
		send_set(67, 2);
		send_random_sets(70);
		wait_all_results();

		send_idle_pct = 78;
		recv_idle_pct = 12;
		send_random_sets(125);
		wait_all_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_set(MAX_ITEMS, MAX_ITEMS - 1);
		// sink stalls while the next sets keep coming
		hold_left = HOLD_CYCLES;
		send_random_sets(60);
		wait_all_results();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
